// File: rtl/rpn_pkg.sv
// package: shared types, character codes and helpers for the rpn evaluator
`timescale 1ns / 1ps

package rpn_pkg;

   localparam int DATA_W          = 32;
   localparam int CHAR_W          = 8;
   localparam int STACK_DEPTH_DEF = 16;

   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_STAR  = 8'h2A;
   localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_FEW   = 3'd1,
      ST_DIV0  = 3'd2,
      ST_BADCH = 3'd3,
      ST_COUNT = 3'd4,
      ST_OVF   = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      CLS_SPACE = 2'd0,
      CLS_DIGIT = 2'd1,
      CLS_OPER  = 2'd2,
      CLS_OTHER = 2'd3
   } class_type;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef struct packed {
      logic       capture;
      logic       push;
      logic       rd_issue;
      logic       alu_load;
      logic       div_start;
      logic       div_load;
      logic       set_err;
      status_type err_code;
      logic       finish_last;
   } ctrl_cmd_type;

   typedef struct packed {
      class_type cls;
      op_type    op;
      logic      err_set;
      logic      is_last;
      logic      full;
      logic      count_lt2;
      logic      b_zero;
      logic      div_done;
      logic      out_free;
   } dp_stat_type;

   function automatic class_type classify(input logic [CHAR_W-1:0] c);
      class_type cls;
      if (c inside {[CHAR_TAB:CHAR_CR], CHAR_SPACE}) begin
         cls = CLS_SPACE;
      end else if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
         cls = CLS_DIGIT;
      end else if (c inside {CHAR_PLUS, CHAR_MINUS, CHAR_STAR, CHAR_SLASH}) begin
         cls = CLS_OPER;
      end else begin
         cls = CLS_OTHER;
      end
      return cls;
   endfunction

   function automatic op_type decode_op(input logic [CHAR_W-1:0] c);
      op_type op;
      case (c)
         CHAR_PLUS:  op = OP_ADD;
         CHAR_MINUS: op = OP_SUB;
         CHAR_STAR:  op = OP_MUL;
         default:    op = OP_DIV;
      endcase
      return op;
   endfunction

endpackage

// File: rtl/rpn_if.sv
// interfaces: character request channel and result channel
`timescale 1ns / 1ps

interface rpn_req_if import rpn_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              is_last;

   modport source (output valid, output char_code, output is_last, input ready);
   modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface rpn_rsp_if import rpn_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] value;
   logic [2:0]               status;

   modport source (output valid, output value, output status, input ready);
   modport sink   (input valid, input value, input status, output ready);
endinterface

// File: rtl/rpn_divider.sv
// signed truncating divider, one quotient bit per cycle by shift and subtract
`timescale 1ns / 1ps

module rpn_divider import rpn_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DATA_W-1:0] dividend,
   input  logic [DATA_W-1:0] divisor,
   output logic              done,
   output logic [DATA_W-1:0] quotient
);

   localparam int STEP_W = $clog2(DATA_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] den_ff, den_in;
   logic              neg_ff, neg_in;
   logic [DATA_W:0]   rem_shift;
   logic [DATA_W:0]   rem_diff;
   logic              fits;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[DATA_W-1]};
      rem_diff  = rem_shift - {1'b0, den_ff};
      fits      = rem_shift >= {1'b0, den_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;

      if (start) begin
         // work on magnitudes, fix the sign at the end
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
         den_in  = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
         neg_in  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
      end else if (busy_ff) begin
         rem_in  = fits ? rem_diff[DATA_W-1:0] : rem_shift[DATA_W-1:0];
         quo_in  = {quo_ff[DATA_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

endmodule

// File: rtl/rpn_datapath.sv
// datapath: character register, operand stack, alu, divider, error latch, result register
`timescale 1ns / 1ps

module rpn_datapath import rpn_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [CHAR_W-1:0]        char_code,
   input  logic                     is_last,
   input  ctrl_cmd_type             cmd,
   output dp_stat_type              stat,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output logic signed [DATA_W-1:0] rsp_value,
   output logic [2:0]               rsp_status
);

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W = $clog2(STACK_DEPTH);

   // entries below the top; the top itself lives in top_ff
   logic [DATA_W-1:0] stack_mem [STACK_DEPTH];

   logic [CHAR_W-1:0] char_ff;
   logic              last_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   status_type        err_ff, err_in;
   logic [DATA_W-1:0] top_ff, top_in;
   logic [DATA_W-1:0] rd_data_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   status_type        rsp_status_ff, rsp_status_in;

   logic [CNT_W-1:0]  count_m1, count_m2;
   logic [CHAR_W-1:0] digit_raw;
   logic [DATA_W-1:0] digit_word;
   logic [DATA_W-1:0] alu_res;
   logic              div_done;
   logic [DATA_W-1:0] div_quo;
   op_type            op_sel;

   assign count_m1   = count_ff - 1'b1;
   assign count_m2   = count_ff - CNT_W'(2);
   assign digit_raw  = char_ff - CHAR_ZERO;
   assign digit_word = {{(DATA_W - 4){1'b0}}, digit_raw[3:0]};
   assign op_sel     = decode_op(char_ff);

   always_comb begin
      case (op_sel)
         OP_ADD:  alu_res = rd_data_ff + top_ff;
         OP_SUB:  alu_res = rd_data_ff - top_ff;
         OP_MUL:  alu_res = rd_data_ff * top_ff;
         default: alu_res = '0;
      endcase
   end

   rpn_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (rd_data_ff),
      .divisor  (top_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      count_in      = count_ff;
      err_in        = err_ff;
      top_in        = top_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.push) begin
         top_in   = digit_word;
         count_in = count_ff + 1'b1;
      end else if (cmd.alu_load) begin
         top_in   = alu_res;
         count_in = count_m1;
      end else if (cmd.div_load) begin
         top_in   = div_quo;
         count_in = count_m1;
      end

      if (cmd.set_err) begin
         err_in = cmd.err_code;
      end

      if (cmd.finish_last) begin
         rsp_valid_in = 1'b1;
         if (err_ff != ST_OK) begin
            rsp_status_in = err_ff;
            rsp_value_in  = '0;
         end else if (count_ff != CNT_W'(1)) begin
            rsp_status_in = ST_COUNT;
            rsp_value_in  = '0;
         end else begin
            rsp_status_in = ST_OK;
            rsp_value_in  = top_ff;
         end
         count_in = '0;
         err_in   = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         char_ff <= char_code;
         last_ff <= is_last;
      end
      top_ff        <= top_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   // old top spills into the memory on a push
   always_ff @(posedge clock) begin
      if (cmd.push && (count_ff != '0)) begin
         stack_mem[count_m1[IDX_W-1:0]] <= top_ff;
      end
      if (cmd.rd_issue) begin
         rd_data_ff <= stack_mem[count_m2[IDX_W-1:0]];
      end
   end

   always_comb begin
      stat.cls       = classify(char_ff);
      stat.op        = op_sel;
      stat.err_set   = err_ff != ST_OK;
      stat.is_last   = last_ff;
      stat.full      = count_ff == CNT_W'(STACK_DEPTH);
      stat.count_lt2 = count_ff < CNT_W'(2);
      stat.b_zero    = top_ff == '0;
      stat.div_done  = div_done;
      stat.out_free  = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

endmodule

// File: rtl/rpn_ctrl.sv
// controller: per-character sequencing of the evaluator datapath
`timescale 1ns / 1ps

module rpn_ctrl import rpn_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_DECODE = 5'b00010,
      S_READ   = 5'b00100,
      S_DIV    = 5'b01000,
      S_FINISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = state_ff == S_IDLE;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.err_code = ST_OK;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_FINISH;
            if (stat.err_set || (stat.cls == CLS_SPACE)) begin
               // nothing to do for this word
            end else if (stat.cls == CLS_DIGIT) begin
               if (stat.full) begin
                  cmd.set_err  = 1'b1;
                  cmd.err_code = ST_OVF;
               end else begin
                  cmd.push = 1'b1;
               end
            end else if (stat.count_lt2) begin
               // operand check comes before the character check
               cmd.set_err  = 1'b1;
               cmd.err_code = ST_FEW;
            end else if (stat.cls == CLS_OTHER) begin
               cmd.set_err  = 1'b1;
               cmd.err_code = ST_BADCH;
            end else begin
               cmd.rd_issue = 1'b1;
               state_in     = S_READ;
            end
         end
         S_READ: begin
            if (stat.op == OP_DIV) begin
               if (stat.b_zero) begin
                  cmd.set_err  = 1'b1;
                  cmd.err_code = ST_DIV0;
                  state_in     = S_FINISH;
               end else begin
                  cmd.div_start = 1'b1;
                  state_in      = S_DIV;
               end
            end else begin
               cmd.alu_load = 1'b1;
               state_in     = S_FINISH;
            end
         end
         S_DIV: begin
            if (stat.div_done) begin
               cmd.div_load = 1'b1;
               state_in     = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!stat.is_last) begin
               state_in = S_IDLE;
            end else if (stat.out_free) begin
               cmd.finish_last = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/rpn_digit_expression_evaluator_unit.sv
// Reverse Polish evaluator for single-digit operands, one character word at a time.
// Whitespace and digits pass through decode and finish; + - * also through a stack read.
// Division adds the 32-step shift-subtract divider; a zero divisor skips it with an error.
// The result of a last character shows on rsp in the cycle after its processing ends.
// Synchronous active-high reset empties the stack, clears the error and the result valid.
`timescale 1ns / 1ps

module rpn_digit_expression_evaluator_unit import rpn_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   rpn_req_if.sink      req_bus,
   rpn_rsp_if.source    rsp_bus
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;
   logic         ready;

   rpn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rpn_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .char_code  (req_bus.char_code),
      .is_last    (req_bus.is_last),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_ready  (rsp_bus.ready),
      .rsp_valid  (rsp_bus.valid),
      .rsp_value  (rsp_bus.value),
      .rsp_status (rsp_bus.status)
   );

   assign req_bus.ready = ready;

endmodule

// File: rtl/rpn_checker.sv
// checker on the evaluator ports, bound to the top level
`timescale 1ns / 1ps

module rpn_checker import rpn_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [DATA_W-1:0] rsp_value,
   input logic [2:0]               rsp_status
);

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= ST_OVF))
      else $error("result status out of range");

   a_error_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |-> (rsp_value == '0))
      else $error("error result carries a non-zero value");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_value) && $stable(rsp_status)))
      else $error("stalled result word changed");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind rpn_digit_expression_evaluator_unit rpn_checker u_rpn_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_value  (rsp_bus.value),
   .rsp_status (rsp_bus.status)
);
